// ----- hw/rtl/rbe_pkg.sv -----
// Shared types and constants of the biphase duration encoder.
`timescale 1ns / 1ps
package rbe_pkg;

  localparam int unsigned DurW     = 17;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned NumRes   = 3;
  localparam int unsigned ResIdxW  = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPulseTime  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSpaceTime  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLeadTime   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTogglePos  = 2'd3;

  localparam logic [CfgW-1:0] PulseTimeRst = 16'd889;
  localparam logic [CfgW-1:0] SpaceTimeRst = 16'd889;
  localparam logic [CfgW-1:0] LeadTimeRst  = 16'd0;
  localparam logic [PosW-1:0] TogglePosRst = 6'd0;

  // Highest position reached; from it the position drops to zero and sticks there
  localparam logic [PosW-1:0] PosMax = 6'd63;

  typedef struct packed {
    logic [CfgW-1:0] pulse_time;
    logic [CfgW-1:0] space_time;
    logic [CfgW-1:0] lead_time;
    logic [PosW-1:0] toggle_position;
  } cfg_t;

  typedef struct packed {
    logic bit_value;
    logic toggle_invert;
    logic first_bit;
    logic last_bit;
  } in_t;

  typedef struct packed {
    logic [DurW-1:0] duration;
    logic            is_pulse;
    logic            frame_end;
  } res_t;

  // One bit's worth of results: slots 0..last_idx are valid, in order
  typedef struct packed {
    res_t [NumRes-1:0]  res;
    logic [ResIdxW-1:0] last_idx;
  } cmd_t;

endpackage

// ----- hw/rtl/rc5_biphase_duration_encoder_core.sv -----
// Top level of the RC5 biphase duration encoder.
`timescale 1ns / 1ps
// Takes one command bit per input transfer and produces the biphase line
// durations of the frame, one duration per output transfer. A one is sent as
// space then pulse, a zero as pulse then space; the second half of each bit is
// held back so equal-level halves of neighbouring bits come out merged. A bit
// flagged first (tuser) restarts the position count and preloads the lead pulse
// if lead_time is non-zero; a bit flagged last (tlast) flushes the held half
// with tlast set on the output. Each bit yields one to three durations.
// Timing: an input transfer is taken in any cycle the two-entry queue has
// room; the output side emits one duration per cycle while m_axis_tready is
// high, the serialiser in the back end being the limit. A bit's first output
// passes the queue entry and the output register. The user must write registers
// through the cfg port only while the block is idle; the block does not enforce it.
module rc5_biphase_duration_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input bits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] bit_value, [1] toggle_invert, rest zero
  input  logic        s_axis_tuser,   // first_bit
  input  logic        s_axis_tlast,   // last_bit
  // output durations
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] duration, rest zero
  output logic        m_axis_tuser,   // is_pulse
  output logic        m_axis_tlast    // frame_end
);
  import rbe_pkg::*;

  cfg_t cfg_q;
  in_t  in_data;
  cmd_t push_cmd, pop_cmd;
  logic push_valid, q_ready, q_valid, q_pop;
  res_t out_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_time      <= PulseTimeRst;
      cfg_q.space_time      <= SpaceTimeRst;
      cfg_q.lead_time       <= LeadTimeRst;
      cfg_q.toggle_position <= TogglePosRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPulseTime: cfg_q.pulse_time      <= cfg_data_i;
        RegSpaceTime: cfg_q.space_time      <= cfg_data_i;
        RegLeadTime:  cfg_q.lead_time       <= cfg_data_i;
        RegTogglePos: cfg_q.toggle_position <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  assign in_data.bit_value     = s_axis_tdata[0];
  assign in_data.toggle_invert = s_axis_tdata[1];
  assign in_data.first_bit     = s_axis_tuser;
  assign in_data.last_bit      = s_axis_tlast;
  assign s_axis_tready         = q_ready;

  rbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (in_data),
    .q_ready_i  (q_ready),
    .q_valid_o  (push_valid),
    .q_cmd_o    (push_cmd)
  );

  rbe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd),
    .pop_i      (q_pop)
  );

  rbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OutDataW-DurW){1'b0}}, out_res.duration};
  assign m_axis_tuser = out_res.is_pulse;
  assign m_axis_tlast = out_res.frame_end;

endmodule

// ----- hw/rtl/rbe_front.sv -----
// Front end: tracks frame state and turns each bit into its list of durations.
`timescale 1ns / 1ps
module rbe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rbe_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  input  rbe_pkg::in_t  in_data_i,
  input  logic          q_ready_i,
  output logic          q_valid_o,
  output rbe_pkg::cmd_t q_cmd_o
);
  import rbe_pkg::*;

  typedef enum logic [1:0] {
    KindEmpty = 2'd0,
    KindPulse = 2'd1,
    KindSpace = 2'd2
  } kind_e;

  logic [DurW-1:0] held_dur_q, held_dur_d;
  kind_e           held_kind_q, held_kind_d;
  logic [PosW-1:0] bit_pos_q, bit_pos_d;

  logic [DurW-1:0] cur_dur;
  kind_e           cur_kind;
  logic            bit_eff;
  logic            pre_v;
  res_t            pre_res, mid_res, last_res;
  logic [DurW-1:0] new_dur;
  logic [DurW-1:0] pulse_ext, space_ext;
  logic            accept;

  assign accept    = in_valid_i & q_ready_i;
  assign pulse_ext = {1'b0, cfg_i.pulse_time};
  assign space_ext = {1'b0, cfg_i.space_time};

  always_comb begin
    // A first bit drops whatever is held and preloads the lead pulse if lead_time is non-zero
    if (in_data_i.first_bit) begin
      bit_pos_d = 6'd1;
      if (cfg_i.lead_time != '0) begin
        cur_dur  = {1'b0, cfg_i.lead_time};
        cur_kind = KindPulse;
      end else begin
        cur_dur  = '0;
        cur_kind = KindEmpty;
      end
    end else begin
      cur_dur  = held_dur_q;
      cur_kind = held_kind_q;
      if (bit_pos_q == '0 || bit_pos_q >= PosMax) begin
        bit_pos_d = '0;
      end else begin
        bit_pos_d = bit_pos_q + 6'd1;
      end
    end

    bit_eff = in_data_i.bit_value ^ ((cfg_i.toggle_position != '0)
              & (bit_pos_d == cfg_i.toggle_position) & in_data_i.toggle_invert);

    if (bit_eff) begin
      // one: space then pulse; a held space merges with the first half
      pre_v   = (cur_kind == KindPulse);
      pre_res = '{duration: cur_dur, is_pulse: 1'b1, frame_end: 1'b0};
      mid_res = '{duration: (cur_kind == KindSpace) ? cur_dur + space_ext : space_ext,
                  is_pulse: 1'b0, frame_end: 1'b0};
      new_dur = pulse_ext;
    end else begin
      // zero: pulse then space; a held pulse merges with the first half
      pre_v   = (cur_kind == KindSpace);
      pre_res = '{duration: cur_dur, is_pulse: 1'b0, frame_end: 1'b0};
      mid_res = '{duration: (cur_kind == KindPulse) ? cur_dur + pulse_ext : pulse_ext,
                  is_pulse: 1'b1, frame_end: 1'b0};
      new_dur = space_ext;
    end
    last_res = '{duration: new_dur, is_pulse: bit_eff, frame_end: 1'b1};

    if (in_data_i.last_bit) begin
      held_dur_d  = '0;
      held_kind_d = KindEmpty;
    end else begin
      held_dur_d  = new_dur;
      held_kind_d = bit_eff ? KindPulse : KindSpace;
    end

    q_cmd_o.res[0]   = pre_v ? pre_res : mid_res;
    q_cmd_o.res[1]   = pre_v ? mid_res : last_res;
    q_cmd_o.res[2]   = last_res;
    q_cmd_o.last_idx = {1'b0, pre_v} + {1'b0, in_data_i.last_bit};
  end

  assign q_valid_o = in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_dur_q  <= '0;
      held_kind_q <= KindEmpty;
      bit_pos_q   <= '0;
    end else if (accept) begin
      held_dur_q  <= held_dur_d;
      held_kind_q <= held_kind_d;
      bit_pos_q   <= bit_pos_d;
    end
  end

endmodule

// ----- hw/rtl/rbe_queue.sv -----
// Two-entry queue of per-bit result lists between front and back end.
`timescale 1ns / 1ps
module rbe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbe_pkg::cmd_t push_cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  output rbe_pkg::cmd_t pop_cmd_o,
  input  logic          pop_i
);
  import rbe_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign ready_o   = (count_q != 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i & ready_o;
  assign do_pop    = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- hw/rtl/rbe_back.sv -----
// Back end: walks each queued list and drives one duration per transfer.
`timescale 1ns / 1ps
module rbe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  rbe_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  output rbe_pkg::res_t out_res_o,
  input  logic          out_ready_i
);
  import rbe_pkg::*;

  logic [ResIdxW-1:0] idx_q;
  logic               out_valid_q;
  res_t               out_res_q;
  logic               load;

  assign load        = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o     = load & (idx_q == q_cmd_i.last_idx);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= q_cmd_i.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= q_pop_o ? '0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/rbe_checker.sv -----
// Port-level checks of the encoder core, bound to the top level.
`timescale 1ns / 1ps
module rbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // output register is empty while reset is applied
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // a stalled output transfer keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  // padding above the duration stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
    else $error("output padding not zero");

  // every accepted bit has a duration on offer once it has passed the queue and output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_axis_tvalid && s_axis_tready, 2) && $past(rst_ni, 1) && $past(rst_ni, 2)
    |-> m_axis_tvalid)
    else $error("no output after input transfer");

endmodule

bind rc5_biphase_duration_encoder_core rbe_checker u_rbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
